// ===== design/tsf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsf_pkg
// Shared widths, register codes and reset values for the tachometer speed
// filter.
// ----------------------------------------------------------------------------
package tsf_pkg;

    // period counter and filter format
    localparam int PERIOD_W    = 16;
    localparam int FRAC_W      = 8;
    localparam int FPER_W      = PERIOD_W + FRAC_W;
    localparam int RESULT_CNT_W = 16;

    // speed format
    localparam int SPEED_W     = 24;
    localparam int SPEED_SHIFT = 4;
    localparam int NUM_W       = 24;

    // filter gain, Q1.8
    localparam int ALPHA_W     = 9;
    localparam int ALPHA_SHIFT = 8;
    localparam int PROD_W      = ALPHA_W + FPER_W;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << ALPHA_SHIFT);

    // divider
    localparam int DIV_W  = FPER_W;
    localparam int DVD_W  = NUM_W + SPEED_SHIFT + FRAC_W;
    localparam int CNT_W  = $clog2(SPEED_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SPEED_W - 1);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int TIMEOUT_W  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA     = 2'd0,
        CFG_NUMERATOR = 2'd1,
        CFG_TIMEOUT   = 2'd2
    } cfg_index_t;

    localparam logic [ALPHA_W-1:0]   ALPHA_RESET   = ALPHA_W'(51);
    localparam logic [NUM_W-1:0]     NUM_RESET     = NUM_W'(299199);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(10000);

    // stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 2 * SPEED_W;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage : tsf_pkg
`default_nettype wire

// ===== design/tachometer_speed_filter_top.sv =====
`default_nettype none
// Flow: a tick with no result is taken and the block stays ready for the next tick.
// A timeout tick goes through S_STORE to the output register.
// A rising-edge tick goes through S_MUL and S_ADD for the filter multiply and add, then
// two passes of the shared serial divider (a saturating quotient skips its pass), then
// S_STORE. One tick is in work at a time; S_STORE waits while the output is held.
// Synchronous reset (aresetn) clears control and filter state and loads register defaults.
// ----------------------------------------------------------------------------
// tachometer_speed_filter_top
// Period-measuring tachometer with first-order period filter and speed output.
// ----------------------------------------------------------------------------
module tachometer_speed_filter_top
    import tsf_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // sample stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [0] feedback_level
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,   // [23:0] speed_filtered, [47:24] speed_raw
    output logic                       m_tuser    // [0] timed_out
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_MUL    = 8'b0000_0010,
        S_ADD    = 8'b0000_0100,
        S_FSTART = 8'b0000_1000,
        S_FWAIT  = 8'b0001_0000,
        S_RSTART = 8'b0010_0000,
        S_RWAIT  = 8'b0100_0000,
        S_STORE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [ALPHA_W-1:0]   alpha_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    // tick state
    logic                    last_level_reg;
    logic [PERIOD_W-1:0]     tse_reg;
    logic [RESULT_CNT_W-1:0] tsr_reg;
    logic [FPER_W-1:0]       pf_reg;
    logic [PERIOD_W-1:0]     praw_reg;

    // filter step
    logic [FPER_W-1:0] step_reg;
    logic              up_reg;

    // pending result
    logic [SPEED_W-1:0] res_f_reg;
    logic [SPEED_W-1:0] res_r_reg;
    logic               res_to_reg;

    // output register
    logic               m_valid_reg;
    logic [SPEED_W-1:0] m_f_reg;
    logic [SPEED_W-1:0] m_r_reg;
    logic               m_to_reg;

    logic                    accept;
    logic                    level;
    logic                    rising;
    logic [PERIOD_W-1:0]     tse_next;
    logic [RESULT_CNT_W-1:0] tsr_next;
    logic                    timeout_hit;
    logic [FPER_W-1:0]       target;
    logic                    ge;
    logic [FPER_W-1:0]       absd;
    logic [PROD_W-1:0]       prod;
    logic [ALPHA_W-1:0]      alpha_next;
    logic                    out_free;

    logic               div_start;
    logic [DVD_W-1:0]   div_dividend;
    logic [DIV_W-1:0]   div_divisor;
    logic [SPEED_W-1:0] div_quotient;
    div_status_t        div_status;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign level     = s_tdata[0];
    assign rising    = level && !last_level_reg;

    assign tse_next    = (tse_reg == {PERIOD_W{1'b1}}) ? tse_reg : tse_reg + PERIOD_W'(1);
    assign tsr_next    = (tsr_reg == {RESULT_CNT_W{1'b1}}) ? tsr_reg
                                                           : tsr_reg + RESULT_CNT_W'(1);
    assign timeout_hit = (tsr_next >= RESULT_CNT_W'(timeout_reg));

    assign target = {praw_reg, {FRAC_W{1'b0}}};
    assign ge     = (target >= pf_reg);
    assign absd   = ge ? target - pf_reg : pf_reg - target;
    assign prod   = PROD_W'(alpha_reg) * PROD_W'(absd);

    assign alpha_next = (cfg_data[ALPHA_W-1:0] > ALPHA_ONE) ? ALPHA_ONE
                                                            : cfg_data[ALPHA_W-1:0];
    assign out_free   = !m_valid_reg || m_tready;

    assign div_start    = (state_reg == S_FSTART) || (state_reg == S_RSTART);
    assign div_dividend = (state_reg == S_RSTART)
                        ? DVD_W'({num_reg, {SPEED_SHIFT{1'b0}}})
                        : {num_reg, {(SPEED_SHIFT + FRAC_W){1'b0}}};
    assign div_divisor  = (state_reg == S_RSTART) ? DIV_W'(praw_reg) : pf_reg;

    tsf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_status)
    );

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg   <= ALPHA_RESET;
            num_reg     <= NUM_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ALPHA:     alpha_reg   <= alpha_next;
                CFG_NUMERATOR: num_reg     <= cfg_data[NUM_W-1:0];
                CFG_TIMEOUT:   timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (rising) begin
                        state_next = S_MUL;
                    end else if (timeout_hit) begin
                        state_next = S_STORE;
                    end
                end
            end
            S_MUL:    state_next = S_ADD;
            S_ADD:    state_next = S_FSTART;
            S_FSTART: state_next = S_FWAIT;
            S_FWAIT: begin
                if (div_status.done) begin
                    state_next = S_RSTART;
                end
            end
            S_RSTART: state_next = S_RWAIT;
            S_RWAIT: begin
                if (div_status.done) begin
                    state_next = S_STORE;
                end
            end
            S_STORE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            last_level_reg <= 1'b0;
            tse_reg        <= '0;
            tsr_reg        <= '0;
            pf_reg         <= '0;
            praw_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                last_level_reg <= level;
                if (rising) begin
                    praw_reg <= tse_next;
                    tse_reg  <= '0;
                    tsr_reg  <= '0;
                end else begin
                    tse_reg <= tse_next;
                    if (timeout_hit) begin
                        pf_reg   <= '0;
                        praw_reg <= '0;
                        tsr_reg  <= '0;
                    end else begin
                        tsr_reg <= tsr_next;
                    end
                end
            end
            if (state_reg == S_ADD) begin
                pf_reg <= up_reg ? pf_reg + step_reg : pf_reg - step_reg;
            end
            if (state_reg == S_STORE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_to_reg <= !rising;
            if (!rising) begin
                res_f_reg <= '0;
                res_r_reg <= '0;
            end
        end
        if (state_reg == S_MUL) begin
            step_reg <= prod[FPER_W+ALPHA_SHIFT-1:ALPHA_SHIFT];
            up_reg   <= ge;
        end
        if (state_reg == S_FWAIT && div_status.done) begin
            res_f_reg <= div_quotient;
        end
        if (state_reg == S_RWAIT && div_status.done) begin
            res_r_reg <= div_quotient;
        end
        if (state_reg == S_STORE && out_free) begin
            m_f_reg  <= res_f_reg;
            m_r_reg  <= res_r_reg;
            m_to_reg <= res_to_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_r_reg, m_f_reg};
    assign m_tuser  = m_to_reg;

`ifndef SYNTHESIS
    a_timeout_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("timeout report with nonzero speed");

    a_done_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |-> (state_reg == S_FWAIT) || (state_reg == S_RWAIT))
        else $error("divider finished outside a wait state");

    a_edge_starts_filter: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && rising |=> state_reg == S_MUL)
        else $error("rising edge did not start the filter update");

    a_div_idle_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_status.busy)
        else $error("divider started while busy");
`endif

endmodule : tachometer_speed_filter_top
`default_nettype wire

// ===== design/tsf_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsf_div
// Shared restoring divider, one quotient bit per cycle, saturating quotient.
// ----------------------------------------------------------------------------
module tsf_div
    import tsf_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [DVD_W-1:0]   dividend,
    input  wire logic [DIV_W-1:0]   divisor,
    output logic      [SPEED_W-1:0] quotient,
    output div_status_t             status
);

    logic [DIV_W-1:0]   rem_reg;
    logic [SPEED_W-1:0] quo_reg;
    logic [DIV_W-1:0]   dsr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [DIV_W-1:0]   hi;
    logic               sat;
    logic [DIV_W:0]     shifted;
    logic [DIV_W:0]     diff;
    logic               fits;
    logic [DIV_W-1:0]   rem_next;

    assign hi       = DIV_W'(dividend[DVD_W-1:SPEED_W]);
    assign sat      = (hi >= divisor);
    assign shifted  = {rem_reg, quo_reg[SPEED_W-1]};
    assign diff     = shifted - {1'b0, dsr_reg};
    assign fits     = (shifted >= {1'b0, dsr_reg});
    assign rem_next = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                cnt_reg <= '0;
                if (sat) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_CNT) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            rem_reg <= hi;
            dsr_reg <= divisor;
            quo_reg <= sat ? {SPEED_W{1'b1}} : dividend[SPEED_W-1:0];
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[SPEED_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign status   = {busy_reg, done_reg};

endmodule : tsf_div
`default_nettype wire
